@@ hw/rtl/limit_switch_seek_controller_core_defines.svh @@
// Assertion helpers for the seek controller; clk and rst_n must be in scope.
`ifndef LIMIT_SWITCH_SEEK_CONTROLLER_CORE_DEFINES_SVH
`define LIMIT_SWITCH_SEEK_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define LSSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lssc: same-cycle check failed");

// next-cycle implication
`define LSSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lssc: next-cycle check failed");

`endif

@@ hw/rtl/lssc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lssc_pkg;

  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_SWITCH = 3'd1;
  localparam logic [2:0] FN_READ = 3'd2;
  localparam logic [2:0] FN_REF = 3'd3;
  localparam logic [2:0] FN_MOVE = 3'd4;

  localparam logic [2:0] K_ACK = 3'd0;
  localparam logic [2:0] K_STEP = 3'd1;
  localparam logic [2:0] K_READ = 3'd2;
  localparam logic [2:0] K_FOUND = 3'd3;
  localparam logic [2:0] K_FAULT = 3'd4;
  localparam logic [2:0] K_LIMIT = 3'd5;
  localparam logic [2:0] K_IGNORED = 3'd6;

  localparam logic [1:0] REG_INC_STEPS = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_MAX_INC = 2'd2;

  localparam logic [7:0] RST_INC_STEPS = 8'd2;
  localparam logic [3:0] RST_DEBOUNCE = 4'd4;
  localparam logic [15:0] RST_MAX_INC = 16'd4000;

  localparam logic [2:0] STATUS_OK_CODE = 3'b100;

  typedef struct packed {
    logic [7:0] inc_steps;
    logic [3:0] debounce;
    logic [15:0] max_inc;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic direction;
    logic target_level;
    logic switch_level;
    logic [11:0] raw_angle;
    logic [7:0] status;
    logic read_ok;
    logic [15:0] move_count;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic move_direction;
    logic [15:0] move_steps;
    logic signed [31:0] angle_count;
    logic signed [31:0] step_position;
    logic [7:0] encoder_status;
  } result_t;

  function automatic logic reading_valid(input logic ok, input logic [7:0] st);
    return ok && (st[5:3] == STATUS_OK_CODE);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lssc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lssc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lssc_pkg::cfg_t     cfg
);
  import lssc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_INC_STEPS: cfg_nxt.inc_steps = pwdata[7:0];
        REG_DEBOUNCE:  cfg_nxt.debounce = pwdata[3:0];
        REG_MAX_INC:   cfg_nxt.max_inc = pwdata[15:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inc_steps <= RST_INC_STEPS;
      cfg_r.debounce <= RST_DEBOUNCE;
      cfg_r.max_inc <= RST_MAX_INC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INC_STEPS: prdata = {24'd0, cfg_r.inc_steps};
      REG_DEBOUNCE:  prdata = {28'd0, cfg_r.debounce};
      REG_MAX_INC:   prdata = {16'd0, cfg_r.max_inc};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hw/rtl/lssc_unwrap.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lssc_unwrap (
  input  wire logic [11:0]        raw_angle,
  input  wire logic [11:0]        prev_angle,
  input  wire logic signed [31:0] acc_in,
  output logic signed [31:0]      acc_out
);
  // difference folded into -2048..2047 is just the 12-bit two's complement result
  logic [11:0] delta;

  assign delta = raw_angle - prev_angle;
  assign acc_out = acc_in + $signed({{20{delta[11]}}, delta});

endmodule

`default_nettype wire

@@ hw/rtl/lssc_seek_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "limit_switch_seek_controller_core_defines.svh"

module lssc_seek_fsm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            proc,
  input  wire lssc_pkg::item_t item,
  input  wire lssc_pkg::cfg_t  cfg,
  output lssc_pkg::result_t    res
);
  import lssc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SWITCH = 2'd1;
  localparam logic [1:0] PH_STEP_READ = 2'd2;
  localparam logic [1:0] PH_FINAL_READ = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic seek_dir_r, seek_dir_nxt;
  logic seek_tgt_r, seek_tgt_nxt;
  logic [3:0] match_r, match_nxt;
  logic [15:0] incr_r, incr_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [11:0] prev_r, prev_nxt;
  logic [7:0] enc_st_r, enc_st_nxt;
  logic signed [31:0] pos_r, pos_nxt;

  logic signed [31:0] acc_unwrapped;
  logic ok;
  logic [3:0] match_inc;
  logic [15:0] incr_inc;
  logic [2:0] kind;
  logic mdir;
  logic [15:0] msteps;

  lssc_unwrap u_unwrap (
    .raw_angle  (item.raw_angle),
    .prev_angle (prev_r),
    .acc_in     (acc_r),
    .acc_out    (acc_unwrapped)
  );

  assign ok = reading_valid(item.read_ok, item.status);
  assign match_inc = match_r + 4'd1;
  assign incr_inc = incr_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    seek_dir_nxt = seek_dir_r;
    seek_tgt_nxt = seek_tgt_r;
    match_nxt = match_r;
    incr_nxt = incr_r;
    acc_nxt = acc_r;
    prev_nxt = prev_r;
    enc_st_nxt = enc_st_r;
    pos_nxt = pos_r;
    kind = K_IGNORED;
    mdir = 1'b0;
    msteps = 16'd0;
    case (item.func)
      FN_START: begin
        seek_dir_nxt = item.direction;
        seek_tgt_nxt = item.target_level;
        match_nxt = 4'd0;
        incr_nxt = 16'd0;
        if (cfg.max_inc == 16'd0) begin
          phase_nxt = PH_IDLE;
          kind = K_LIMIT;
        end else begin
          phase_nxt = PH_SWITCH;
          kind = K_ACK;
        end
      end
      FN_SWITCH: begin
        if (phase_r == PH_SWITCH) begin
          if (cfg.debounce == 4'd0 || item.switch_level == seek_tgt_r) begin
            if (cfg.debounce == 4'd0 || match_inc >= cfg.debounce) begin
              match_nxt = 4'd0;
              phase_nxt = PH_FINAL_READ;
              kind = K_READ;
            end else begin
              match_nxt = match_inc;
              kind = K_ACK;
            end
          end else begin
            match_nxt = 4'd0;
            if (seek_dir_r) begin
              pos_nxt = pos_r + $signed({24'd0, cfg.inc_steps});
            end else begin
              pos_nxt = pos_r - $signed({24'd0, cfg.inc_steps});
            end
            phase_nxt = PH_STEP_READ;
            kind = K_STEP;
            mdir = seek_dir_r;
            msteps = {8'd0, cfg.inc_steps};
          end
        end
      end
      FN_READ: begin
        if (phase_r != PH_SWITCH) begin
          if (!ok) begin
            phase_nxt = PH_IDLE;
            kind = K_FAULT;
          end else begin
            acc_nxt = acc_unwrapped;
            prev_nxt = item.raw_angle;
            enc_st_nxt = item.status;
            if (phase_r == PH_FINAL_READ) begin
              phase_nxt = PH_IDLE;
              kind = K_FOUND;
            end else if (phase_r == PH_STEP_READ) begin
              incr_nxt = incr_inc;
              if (incr_inc >= cfg.max_inc) begin
                phase_nxt = PH_IDLE;
                kind = K_LIMIT;
              end else begin
                phase_nxt = PH_SWITCH;
                kind = K_ACK;
              end
            end else begin
              kind = K_ACK;
            end
          end
        end
      end
      FN_REF: begin
        if (phase_r == PH_IDLE) begin
          if (ok) begin
            prev_nxt = item.raw_angle;
            enc_st_nxt = item.status;
            kind = K_ACK;
          end else begin
            kind = K_FAULT;
          end
        end
      end
      FN_MOVE: begin
        if (phase_r == PH_IDLE) begin
          if (item.direction) begin
            pos_nxt = pos_r + $signed({16'd0, item.move_count});
          end else begin
            pos_nxt = pos_r - $signed({16'd0, item.move_count});
          end
          kind = K_STEP;
          mdir = item.direction;
          msteps = item.move_count;
        end
      end
      default: kind = K_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seek_dir_r <= 1'b0;
      seek_tgt_r <= 1'b0;
      match_r <= 4'd0;
      incr_r <= 16'd0;
      acc_r <= 32'sd0;
      prev_r <= 12'd0;
      enc_st_r <= 8'd0;
      pos_r <= 32'sd0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      seek_dir_r <= seek_dir_nxt;
      seek_tgt_r <= seek_tgt_nxt;
      match_r <= match_nxt;
      incr_r <= incr_nxt;
      acc_r <= acc_nxt;
      prev_r <= prev_nxt;
      enc_st_r <= enc_st_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    res.kind = kind;
    res.move_direction = mdir;
    res.move_steps = msteps;
    res.angle_count = acc_nxt;
    res.step_position = pos_nxt;
    res.encoder_status = enc_st_nxt;
  end

  `LSSC_ASSERT_NEXT(a_found_ends_seek, proc && kind == K_FOUND, phase_r == PH_IDLE)
  `LSSC_ASSERT_NEXT(a_read_req_arms_final, proc && kind == K_READ, phase_r == PH_FINAL_READ)
  `LSSC_ASSERT_NEXT(a_pos_holds_idle, !proc, $stable(pos_r) && $stable(acc_r))

endmodule

`default_nettype wire

@@ hw/rtl/limit_switch_seek_controller_core.sv @@
// Limit switch seek controller.
// Input stream (in_*): one item per event; in_tuser carries the function code
// (start seek, switch sample, encoder reading, set reference, external move),
// in_tdata the operands. Every accepted item yields exactly one result item
// on out_*: out_tuser is the result kind, out_tdata the commanded move, the
// unwrapped multi-turn angle, the step position and the last encoder status.
// Configuration (increment steps, debounce samples, increment budget) sits on
// the APB port at byte addresses 0, 4 and 8; write only while no seek items
// are in flight.
// An accepted item is held in the input register, then the state update writes
// its result into the result register. Throughput is one item per cycle while
// out_tready is high; the single state update between the registers sets it.
// When out_tready is low the result register holds, the input register still
// takes one more item, and in_tready drops once both are full.
// Synchronous reset clears all seek state, angle and position to zero, loads
// the default configuration and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

`include "limit_switch_seek_controller_core_defines.svh"

module limit_switch_seek_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: direction, target_level, switch_level, raw_angle[11:0],
  //           status[7:0], read_ok, move_count[15:0]
  input  wire logic [39:0] in_tdata,
  // in_tuser: func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: move_direction, move_steps[15:0], angle_count[31:0],
  //            step_position[31:0], encoder_status[7:0], zero pad[6:0]
  output logic [95:0]      out_tdata,
  // out_tuser: kind[2:0]
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lssc_pkg::*;

  cfg_t cfg;
  item_t in_item_r, in_item_nxt;
  logic in_valid_r, in_valid_nxt;
  result_t res;
  result_t out_res_r, out_res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv;
  logic proc;
  logic in_acc;

  lssc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign adv = !out_valid_r || out_tready;
  assign proc = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt = in_item_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
      in_item_nxt.func = in_tuser;
      in_item_nxt.direction = in_tdata[0];
      in_item_nxt.target_level = in_tdata[1];
      in_item_nxt.switch_level = in_tdata[2];
      in_item_nxt.raw_angle = in_tdata[14:3];
      in_item_nxt.status = in_tdata[22:15];
      in_item_nxt.read_ok = in_tdata[23];
      in_item_nxt.move_count = in_tdata[39:24];
    end
  end

  lssc_seek_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt = out_res_r;
    if (adv) begin
      out_valid_nxt = in_valid_r;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_res_r.kind;
  assign out_tdata = {7'd0, out_res_r.encoder_status, out_res_r.step_position,
                      out_res_r.angle_count, out_res_r.move_steps,
                      out_res_r.move_direction};

  `LSSC_ASSERT_NOW(a_no_move_unless_step, out_tvalid && out_tuser != K_STEP,
                   out_tdata[16:0] == 17'd0)
  `LSSC_ASSERT_NEXT(a_stalled_item_kept, in_valid_r && !adv,
                    in_valid_r && $stable(in_item_r))
  `LSSC_ASSERT_NEXT(a_accept_loads, in_acc, in_valid_r)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lssc_pkg::*;

  typedef enum logic [1:0] {
    SEEK_IDLE,
    SEEK_SWITCH,
    SEEK_STEP_READ,
    SEEK_FINAL_READ
  } seek_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  limit_switch_seek_controller_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [7:0]  inc_steps = RST_INC_STEPS;
  logic [3:0]  debounce = RST_DEBOUNCE;
  logic [15:0] max_inc = RST_MAX_INC;
  seek_phase_t seek_phase = SEEK_IDLE;
  logic        seek_dir = 1'b0;
  logic        seek_tgt = 1'b0;
  logic [3:0]  match_cnt = '0;
  logic [15:0] inc_cnt = '0;
  logic [31:0] angle_acc = '0;
  logic [11:0] prev_angle = '0;
  logic [7:0]  enc_status = '0;
  logic [31:0] step_pos = '0;

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      hold_off = 0;

  function automatic result_t predict_seek_result(input item_t it);
    result_t r;
    logic    ok;
    int      d;
    r = '0;
    r.kind = K_IGNORED;
    ok = it.read_ok && (it.status[5:3] == STATUS_OK_CODE);
    case (it.func)
      FN_START: begin
        seek_dir = it.direction;
        seek_tgt = it.target_level;
        match_cnt = '0;
        inc_cnt = '0;
        if (max_inc == 0) begin
          seek_phase = SEEK_IDLE;
          r.kind = K_LIMIT;
        end else begin
          seek_phase = SEEK_SWITCH;
          r.kind = K_ACK;
        end
      end
      FN_SWITCH: begin
        if (seek_phase == SEEK_SWITCH) begin
          if (debounce == 0 || it.switch_level == seek_tgt) begin
            match_cnt = match_cnt + 4'd1;
            if (debounce == 0 || match_cnt >= debounce) begin
              match_cnt = '0;
              seek_phase = SEEK_FINAL_READ;
              r.kind = K_READ;
            end else begin
              r.kind = K_ACK;
            end
          end else begin
            match_cnt = '0;
            step_pos = seek_dir ? step_pos + inc_steps : step_pos - inc_steps;
            seek_phase = SEEK_STEP_READ;
            r.kind = K_STEP;
            r.move_direction = seek_dir;
            r.move_steps = {8'd0, inc_steps};
          end
        end
      end
      FN_READ: begin
        if (seek_phase != SEEK_SWITCH) begin
          if (!ok) begin
            seek_phase = SEEK_IDLE;
            r.kind = K_FAULT;
          end else begin
            // unwrap the 12-bit angle into the shortest signed step
            d = int'(it.raw_angle) - int'(prev_angle);
            if (d > 2047) d = d - 4096;
            if (d < -2048) d = d + 4096;
            angle_acc = angle_acc + d;
            prev_angle = it.raw_angle;
            enc_status = it.status;
            case (seek_phase)
              SEEK_FINAL_READ: begin
                seek_phase = SEEK_IDLE;
                r.kind = K_FOUND;
              end
              SEEK_STEP_READ: begin
                inc_cnt = inc_cnt + 16'd1;
                if (inc_cnt >= max_inc) begin
                  seek_phase = SEEK_IDLE;
                  r.kind = K_LIMIT;
                end else begin
                  seek_phase = SEEK_SWITCH;
                  r.kind = K_ACK;
                end
              end
              default: r.kind = K_ACK;
            endcase
          end
        end
      end
      FN_REF: begin
        if (seek_phase == SEEK_IDLE) begin
          if (ok) begin
            prev_angle = it.raw_angle;
            enc_status = it.status;
            r.kind = K_ACK;
          end else begin
            r.kind = K_FAULT;
          end
        end
      end
      FN_MOVE: begin
        if (seek_phase == SEEK_IDLE) begin
          step_pos = it.direction ? step_pos + it.move_count : step_pos - it.move_count;
          r.kind = K_STEP;
          r.move_direction = it.direction;
          r.move_steps = it.move_count;
        end
      end
      default: ;
    endcase
    r.angle_count = angle_acc;
    r.step_position = step_pos;
    r.encoder_status = enc_status;
    return r;
  endfunction

  // result side: stall pattern plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.move_direction = out_tdata[0];
      got.move_steps = out_tdata[16:1];
      got.angle_count = out_tdata[48:17];
      got.step_position = out_tdata[80:49];
      got.encoder_status = out_tdata[88:81];
      if (expected_results.size() == 0) begin
        $error("unexpected result item: kind %0d", got.kind);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
          mismatch_count++;
        end
        if (got.move_direction !== exp_r.move_direction) begin
          $error("move_direction: expected %0d, got %0d", exp_r.move_direction,
                 got.move_direction);
          mismatch_count++;
        end
        if (got.move_steps !== exp_r.move_steps) begin
          $error("move_steps: expected %0d, got %0d", exp_r.move_steps, got.move_steps);
          mismatch_count++;
        end
        if (got.angle_count !== exp_r.angle_count) begin
          $error("angle_count: expected %0d, got %0d", exp_r.angle_count, got.angle_count);
          mismatch_count++;
        end
        if (got.step_position !== exp_r.step_position) begin
          $error("step_position: expected %0d, got %0d", exp_r.step_position,
                 got.step_position);
          mismatch_count++;
        end
        if (got.encoder_status !== exp_r.encoder_status) begin
          $error("encoder_status: expected 0x%02h, got 0x%02h", exp_r.encoder_status,
                 got.encoder_status);
          mismatch_count++;
        end
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = it.func;
    in_tdata = {it.move_count, it.read_ok, it.status, it.raw_angle,
                it.switch_level, it.target_level, it.direction};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_seek_result(it));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_INC_STEPS: inc_steps = val[7:0];
      REG_DEBOUNCE:  debounce = val[3:0];
      REG_MAX_INC:   max_inc = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] steps, input logic [3:0] deb,
                            input logic [15:0] maxi);
    drain();
    cfg_write(REG_INC_STEPS, {24'd0, steps});
    cfg_write(REG_DEBOUNCE, {28'd0, deb});
    cfg_write(REG_MAX_INC, {16'd0, maxi});
  endtask

  function automatic item_t make_item(input logic [2:0] func, input logic dir,
                                      input logic tgt, input logic lvl,
                                      input logic [11:0] raw, input logic [7:0] st,
                                      input logic ok, input logic [15:0] cnt);
    item_t it;
    it.func = func;
    it.direction = dir;
    it.target_level = tgt;
    it.switch_level = lvl;
    it.raw_angle = raw;
    it.status = st;
    it.read_ok = ok;
    it.move_count = cnt;
    return it;
  endfunction

  function automatic logic [7:0] pick_status(input logic good);
    logic [7:0] s;
    s = 8'($urandom);
    if (good) s[5:3] = STATUS_OK_CODE;
    else if (s[5:3] == STATUS_OK_CODE) s[3] = 1'b1;
    return s;
  endfunction

  // mostly well-formed seek traffic, steered by the predicted phase
  function automatic item_t next_seek_item();
    item_t      it;
    logic [63:0] rnd;
    int         r;
    rnd = {$urandom, $urandom};
    it = rnd[42:0];
    r = $urandom_range(99);
    if ($urandom_range(1)) it.raw_angle = prev_angle + 12'($urandom_range(128)) - 12'd64;
    it.read_ok = ($urandom_range(99) < 93);
    it.status = pick_status($urandom_range(99) < 93);
    case (seek_phase)
      SEEK_IDLE: begin
        if (r < 55) it.func = FN_START;
        else if (r < 65) it.func = FN_READ;
        else if (r < 75) it.func = FN_REF;
        else if (r < 85) it.func = FN_MOVE;
        else if (r < 90) it.func = FN_SWITCH;
      end
      SEEK_SWITCH: begin
        if (r < 88) begin
          it.func = FN_SWITCH;
          it.switch_level = ($urandom_range(99) < 90) ? seek_tgt : ~seek_tgt;
        end else if (r < 92) begin
          it.func = FN_START;
        end
      end
      default: begin
        if (r < 88) it.func = FN_READ;
        else if (r < 92) it.func = FN_SWITCH;
      end
    endcase
    return it;
  endfunction

  task automatic run_random(input int count, input int gpct, input int spct);
    gap_pct = gpct;
    stall_pct = spct;
    repeat (count) send_item(next_seek_item());
    drain();
  endtask

  task automatic test_directed;
    gap_pct = 0;
    stall_pct = 0;
    send_item(make_item(FN_REF, 0, 0, 0, 12'hFFF, 8'h20, 1, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h000, 8'hE7, 1, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h800, 8'h20, 1, 0));
    send_item(make_item(FN_READ, 1, 1, 1, 12'h123, 8'h20, 0, 16'hFFFF));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h456, 8'h18, 1, 0));
    send_item(make_item(FN_REF, 0, 0, 0, 12'h005, 8'hFF, 1, 0));
    send_item(make_item(FN_MOVE, 1, 0, 0, 0, 0, 0, 16'hFFFF));
    send_item(make_item(FN_MOVE, 0, 0, 0, 0, 0, 0, 16'h0000));
    send_item(make_item(FN_SWITCH, 0, 0, 1, 0, 0, 0, 0));
    send_item(make_item(3'd5, 1, 1, 1, 12'hFFF, 8'h20, 1, 16'hFFFF));
    send_item(make_item(3'd7, 1, 1, 1, 12'hFFF, 8'h20, 1, 16'hFFFF));
    send_item(make_item(FN_START, 1, 1, 0, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h010, 8'h20, 1, 0));
    send_item(make_item(FN_REF, 0, 0, 0, 12'h010, 8'h20, 1, 0));
    send_item(make_item(FN_MOVE, 1, 0, 0, 0, 0, 0, 16'd100));
    send_item(make_item(FN_SWITCH, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FN_SWITCH, 0, 0, 1, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'hFF0, 8'h24, 1, 0));
    repeat (4) send_item(make_item(FN_SWITCH, 0, 0, 1, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h7F0, 8'hA0, 1, 0));
    send_item(make_item(FN_START, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FN_START, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FN_SWITCH, 0, 0, 1, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h100, 8'h20, 0, 0));
    drain();
  endtask

  task automatic test_config_extremes;
    // zero budget: a start fails at once
    set_config(8'd255, 4'd15, 16'd0);
    send_item(make_item(FN_START, 1, 1, 0, 0, 0, 0, 0));
    // budget of one increment runs into the travel limit
    set_config(8'd255, 4'd15, 16'd1);
    send_item(make_item(FN_START, 1, 1, 0, 0, 0, 0, 0));
    send_item(make_item(FN_SWITCH, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h3FF, 8'h20, 1, 0));
    // zero debounce: any sample completes the debounce
    set_config(8'd1, 4'd0, 16'd65535);
    send_item(make_item(FN_START, 0, 1, 0, 0, 0, 0, 0));
    send_item(make_item(FN_SWITCH, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FN_READ, 0, 0, 0, 12'h400, 8'h20, 1, 0));
    drain();
  endtask

  task automatic test_random_traffic;
    set_config(8'd255, 4'd15, 16'd65535);
    run_random(400, 0, 0);
    set_config(8'd1, 4'd1, 16'd3);
    run_random(400, 81, 0);
    set_config(8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
               16'($urandom_range(1, 6)));
    run_random(400, 0, 81);
    set_config(8'($urandom_range(1, 255)), 4'($urandom_range(1, 6)),
               16'($urandom_range(1, 65535)));
    run_random(450, 12, 12);
  endtask

  task automatic test_backpressure;
    set_config(RST_INC_STEPS, RST_DEBOUNCE, RST_MAX_INC);
    gap_pct = 0;
    stall_pct = 0;
    hold_off = 300;
    repeat (60) send_item(next_seek_item());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
